[hdl/stok_pkg.sv]
// ----------------------------------------------------------------------------
// stok_pkg
// Shared types, token codes and keyword tables for the source tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

    localparam int unsigned MAX_WORD_LEN   = 255;
    localparam int unsigned MAX_STRING_LEN = 1023;
    localparam int unsigned CNT_W          = 10;
    localparam int unsigned RQ_DEPTH       = 4;
    localparam int unsigned RQ_PTR_W       = $clog2(RQ_DEPTH);
    localparam int unsigned RQ_CNT_W       = $clog2(RQ_DEPTH + 1);

    localparam logic [4:0] K_EOF     = 5'd0;
    localparam logic [4:0] K_KEYWORD = 5'd1;
    localparam logic [4:0] K_ID      = 5'd2;
    localparam logic [4:0] K_INT     = 5'd3;
    localparam logic [4:0] K_STRING  = 5'd4;
    localparam logic [4:0] K_AT      = 5'd5;
    localparam logic [4:0] K_COLONEQ = 5'd6;
    localparam logic [4:0] K_COLON   = 5'd7;
    localparam logic [4:0] K_LARROW  = 5'd8;
    localparam logic [4:0] K_LTE     = 5'd9;
    localparam logic [4:0] K_LT      = 5'd10;
    localparam logic [4:0] K_ARROW   = 5'd11;
    localparam logic [4:0] K_MINUS   = 5'd12;
    localparam logic [4:0] K_EQ      = 5'd13;
    localparam logic [4:0] K_NEQ     = 5'd14;
    localparam logic [4:0] K_DOT     = 5'd15;
    localparam logic [4:0] K_LPAREN  = 5'd16;
    localparam logic [4:0] K_RPAREN  = 5'd17;
    localparam logic [4:0] K_LBRACE  = 5'd18;
    localparam logic [4:0] K_RBRACE  = 5'd19;
    localparam logic [4:0] K_LBRACK  = 5'd20;
    localparam logic [4:0] K_RBRACK  = 5'd21;
    localparam logic [4:0] K_COMMA   = 5'd22;
    localparam logic [4:0] K_BAR     = 5'd23;
    localparam logic [4:0] K_PLUS    = 5'd24;
    localparam logic [4:0] K_STAR    = 5'd25;
    localparam logic [4:0] K_SLASH   = 5'd26;
    localparam logic [4:0] K_GTE     = 5'd27;
    localparam logic [4:0] K_GT      = 5'd28;

    localparam logic [3:0] KW_EQ_INDEX = 4'd8;

    localparam logic [0:7][0:4][7:0] KW_TEXT = {
        {"def", 16'h0}, {"data", 8'h0}, {"var", 16'h0}, {"if", 24'h0},
        {"then", 8'h0}, {"else", 8'h0}, "match", {"with", 8'h0}
    };
    localparam logic [0:7][2:0] KW_LEN = {
        3'd3, 3'd4, 3'd3, 3'd2, 3'd4, 3'd4, 3'd5, 3'd4
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_text;
    } item_t;

    typedef struct packed {
        logic             is_value_char;
        logic [7:0]       value_char;
        logic [4:0]       token_kind;
        logic [3:0]       keyword_index;
        logic [CNT_W-1:0] token_length;
        logic             lex_error;
    } result_t;

    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } res_pair_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] index;
    } kw_hit_t;

    function automatic kw_hit_t kw_lookup(input logic [0:4][7:0] prefix,
                                          input logic [CNT_W-1:0] len);
        kw_hit_t res;
        logic    m;
        res = '0;
        for (int k = 7; k >= 0; k--)
        begin
            m = (len == {{(CNT_W-3){1'b0}}, KW_LEN[k]});
            for (int i = 0; i < 5; i++)
            begin
                if (i < int'(KW_LEN[k]) && prefix[i] != KW_TEXT[k][i])
                begin
                    m = 1'b0;
                end
            end
            if (m)
            begin
                res.hit   = 1'b1;
                res.index = 4'(k);
            end
        end
        return res;
    endfunction

    function automatic logic [4:0] single_kind(input logic [7:0] c);
        logic [4:0] k;
        unique case (c)
            8'h2E:   k = K_DOT;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h5B:   k = K_LBRACK;
            8'h5D:   k = K_RBRACK;
            8'h2C:   k = K_COMMA;
            8'h7C:   k = K_BAR;
            8'h2B:   k = K_PLUS;
            8'h2A:   k = K_STAR;
            8'h2F:   k = K_SLASH;
            default: k = K_EOF;
        endcase
        return k;
    endfunction

endpackage

[hdl/stok_if.sv]
// ----------------------------------------------------------------------------
// stok_if
// Valid/ready channels for source characters and token results.
// ----------------------------------------------------------------------------
interface stok_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_text;

    modport source(output valid, ch, end_of_text, input ready);
    modport sink(input valid, ch, end_of_text, output ready);
endinterface

interface stok_tok_if;
    logic       valid;
    logic       ready;
    logic       is_value_char;
    logic [7:0] value_char;
    logic [4:0] token_kind;
    logic [3:0] keyword_index;
    logic [9:0] token_length;
    logic       lex_error;

    modport source(output valid, is_value_char, value_char, token_kind,
                   keyword_index, token_length, lex_error, input ready);
    modport sink(input valid, is_value_char, value_char, token_kind,
                 keyword_index, token_length, lex_error, output ready);
endinterface

[hdl/stok_step.sv]
// ----------------------------------------------------------------------------
// stok_step
// Scan mode machine: consumes one character and yields up to two words.
// ----------------------------------------------------------------------------
module stok_step
    import stok_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  item_t     item,
    output res_pair_t res
);

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_COMMENT = 4'd1;
    localparam logic [3:0] M_WORD    = 4'd2;
    localparam logic [3:0] M_NUMBER  = 4'd3;
    localparam logic [3:0] M_STRING  = 4'd4;
    localparam logic [3:0] M_COLON   = 4'd5;
    localparam logic [3:0] M_LT      = 4'd6;
    localparam logic [3:0] M_MINUS   = 4'd7;
    localparam logic [3:0] M_EQ      = 4'd8;
    localparam logic [3:0] M_BANG    = 4'd9;
    localparam logic [3:0] M_GT      = 4'd10;

    logic [3:0]       mode_reg, mode_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             halt_reg, halt_next;
    logic [0:4][7:0]  prefix_reg;

    logic             pw_en;
    logic [2:0]       pw_idx;

    logic             b_v, b_err, b_pw;
    result_t          b_r;
    logic [3:0]       b_mode;
    logic [CNT_W-1:0] b_count;

    logic             pre_v, sec_v, use_b, err;
    result_t          pre, sec, close_r, flush_r;
    logic [4:0]       two, sk;
    kw_hit_t          kw;
    logic [7:0]       c;
    logic             c_alpha, c_digit, c_space;

    function automatic result_t mk_val(input logic [7:0] v);
        result_t r;
        r = '0;
        r.is_value_char = 1'b1;
        r.value_char    = v;
        return r;
    endfunction

    function automatic result_t mk_tok(input logic [4:0] kind, input logic [3:0] kwi,
                                       input logic [CNT_W-1:0] len);
        result_t r;
        r = '0;
        r.token_kind    = kind;
        r.keyword_index = kwi;
        r.token_length  = len;
        return r;
    endfunction

    function automatic result_t mk_err();
        result_t r;
        r = '0;
        r.lex_error = 1'b1;
        return r;
    endfunction

    assign c       = item.ch;
    assign c_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    assign c_digit = (c >= "0" && c <= "9");
    assign c_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
    assign sk      = single_kind(c);
    assign kw      = kw_lookup(prefix_reg, count_reg);
    assign close_r = kw.hit ? mk_tok(K_KEYWORD, kw.index, count_reg)
                            : mk_tok(K_ID, 4'd0, count_reg);

    always_comb
    begin
        unique case (mode_reg)
            M_COLON: flush_r = mk_tok(K_COLON, 4'd0, '0);
            M_LT:    flush_r = mk_tok(K_LT, 4'd0, '0);
            M_MINUS: flush_r = mk_tok(K_MINUS, 4'd0, '0);
            M_EQ:    flush_r = mk_tok(K_KEYWORD, KW_EQ_INDEX, '0);
            M_GT:    flush_r = mk_tok(K_GT, 4'd0, '0);
            default: flush_r = mk_err();
        endcase
    end

    always_comb
    begin
        two = K_EOF;
        unique case (mode_reg)
            M_COLON: if (c == "=") two = K_COLONEQ;
            M_LT:
            begin
                if (c == "-")
                begin
                    two = K_LARROW;
                end
                else if (c == "=")
                begin
                    two = K_LTE;
                end
            end
            M_MINUS: if (c == ">") two = K_ARROW;
            M_EQ:    if (c == "=") two = K_EQ;
            M_BANG:  if (c == "=") two = K_NEQ;
            M_GT:    if (c == "=") two = K_GTE;
            default: two = K_EOF;
        endcase
    end

    // A character seen between tokens.
    always_comb
    begin
        b_v     = 1'b0;
        b_r     = '0;
        b_mode  = M_IDLE;
        b_count = '0;
        b_err   = 1'b0;
        b_pw    = 1'b0;
        priority if (c_space)
        begin
            b_mode = M_IDLE;
        end
        else if (c == ";")
        begin
            b_mode = M_COMMENT;
        end
        else if (c_alpha || c == "_")
        begin
            b_mode  = M_WORD;
            b_count = CNT_W'(1);
            b_v     = 1'b1;
            b_r     = mk_val(c);
            b_pw    = 1'b1;
        end
        else if (c_digit)
        begin
            b_mode  = M_NUMBER;
            b_count = CNT_W'(1);
            b_v     = 1'b1;
            b_r     = mk_val(c);
        end
        else if (c == "\"")
        begin
            b_mode = M_STRING;
        end
        else if (c == "@")
        begin
            b_v = 1'b1;
            b_r = mk_tok(K_AT, 4'd0, '0);
        end
        else if (c == ":")
        begin
            b_mode = M_COLON;
        end
        else if (c == "<")
        begin
            b_mode = M_LT;
        end
        else if (c == "-")
        begin
            b_mode = M_MINUS;
        end
        else if (c == "=")
        begin
            b_mode = M_EQ;
        end
        else if (c == "!")
        begin
            b_mode = M_BANG;
        end
        else if (c == ">")
        begin
            b_mode = M_GT;
        end
        else if (sk != K_EOF)
        begin
            b_v = 1'b1;
            b_r = mk_tok(sk, 4'd0, '0);
        end
        else
        begin
            b_v   = 1'b1;
            b_r   = mk_err();
            b_err = 1'b1;
        end
    end

    always_comb
    begin
        pre_v      = 1'b0;
        pre        = '0;
        sec_v      = 1'b0;
        sec        = '0;
        use_b      = 1'b0;
        err        = 1'b0;
        mode_next  = mode_reg;
        count_next = count_reg;
        halt_next  = halt_reg;
        pw_en      = 1'b0;
        pw_idx     = count_reg[2:0];

        if (item.end_of_text)
        begin
            if (!halt_reg)
            begin
                unique case (mode_reg)
                    M_WORD:
                    begin
                        pre_v = 1'b1;
                        pre   = close_r;
                    end
                    M_NUMBER:
                    begin
                        pre_v = 1'b1;
                        pre   = mk_tok(K_INT, 4'd0, count_reg);
                    end
                    M_STRING:
                    begin
                        pre_v = 1'b1;
                        pre   = mk_tok(K_STRING, 4'd0, count_reg);
                    end
                    M_COLON, M_LT, M_MINUS, M_EQ, M_BANG, M_GT:
                    begin
                        pre_v = 1'b1;
                        pre   = flush_r;
                    end
                    default:
                    begin
                        pre_v = 1'b0;
                    end
                endcase
            end
            sec_v      = 1'b1;
            sec        = mk_tok(K_EOF, 4'd0, '0);
            mode_next  = M_IDLE;
            count_next = '0;
            halt_next  = 1'b0;
        end
        else if (!halt_reg)
        begin
            unique case (mode_reg)
                M_IDLE:
                begin
                    use_b = 1'b1;
                end
                M_COMMENT:
                begin
                    if (c == 8'h0A)
                    begin
                        mode_next = M_IDLE;
                    end
                end
                M_STRING:
                begin
                    if (c == "\"")
                    begin
                        pre_v      = 1'b1;
                        pre        = mk_tok(K_STRING, 4'd0, count_reg);
                        mode_next  = M_IDLE;
                        count_next = '0;
                    end
                    else if (count_reg >= CNT_W'(MAX_STRING_LEN))
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        pre_v      = 1'b1;
                        pre        = mk_val(c);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                M_WORD, M_NUMBER:
                begin
                    if (c_digit || (mode_reg == M_WORD && (c_alpha || c == "_")))
                    begin
                        if (count_reg >= CNT_W'(MAX_WORD_LEN))
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            pre_v      = 1'b1;
                            pre        = mk_val(c);
                            count_next = count_reg + CNT_W'(1);
                            pw_en      = (mode_reg == M_WORD) && (count_reg < CNT_W'(5));
                        end
                    end
                    else
                    begin
                        pre_v = 1'b1;
                        pre   = (mode_reg == M_WORD) ? close_r
                                                     : mk_tok(K_INT, 4'd0, count_reg);
                        use_b = 1'b1;
                    end
                end
                M_COLON, M_LT, M_MINUS, M_EQ, M_BANG, M_GT:
                begin
                    if (two != K_EOF)
                    begin
                        pre_v     = 1'b1;
                        pre       = mk_tok(two, 4'd0, '0);
                        mode_next = M_IDLE;
                    end
                    else if (mode_reg == M_BANG)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        pre_v = 1'b1;
                        pre   = flush_r;
                        use_b = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = M_IDLE;
                end
            endcase

            if (err)
            begin
                pre_v      = 1'b1;
                pre        = mk_err();
                halt_next  = 1'b1;
                mode_next  = M_IDLE;
                count_next = '0;
            end

            if (use_b)
            begin
                sec_v      = b_v;
                sec        = b_r;
                mode_next  = b_mode;
                count_next = b_count;
                halt_next  = b_err;
                if (b_pw)
                begin
                    pw_en  = 1'b1;
                    pw_idx = 3'd0;
                end
            end
        end

        res.v0 = pre_v | sec_v;
        res.r0 = pre_v ? pre : sec;
        res.v1 = pre_v & sec_v;
        res.r1 = sec;
        if (!fire)
        begin
            res.v0 = 1'b0;
            res.v1 = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            count_reg <= '0;
            halt_reg  <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            halt_reg  <= halt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && pw_en)
        begin
            prefix_reg[pw_idx] <= c;
        end
    end

endmodule

[hdl/stok_rq.sv]
// ----------------------------------------------------------------------------
// stok_rq
// Small result queue that takes up to two words per cycle and gives one.
// ----------------------------------------------------------------------------
module stok_rq
    import stok_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  res_pair_t push,
    input  logic      pop,
    output result_t   head,
    output logic      not_empty,
    output logic      room
);

    result_t               mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [RQ_CNT_W-1:0]   cnt_reg;
    logic [1:0]            n_push;

    assign n_push    = {1'b0, push.v0} + {1'b0, push.v1};
    assign not_empty = (cnt_reg != '0);
    assign room      = (cnt_reg <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem[wr_ptr_reg + RQ_PTR_W'(1)] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + RQ_PTR_W'(n_push);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + RQ_PTR_W'(1);
            end
            cnt_reg <= cnt_reg + RQ_CNT_W'(n_push) - RQ_CNT_W'(pop);
        end
    end

endmodule

[hdl/source_tokenizer.sv]
// ----------------------------------------------------------------------------
// source_tokenizer
// Character-serial tokenizer with keyword recognition and operator lookahead.
// ----------------------------------------------------------------------------
// One source character is taken per cycle while the result queue has room.
// A character is held in an input register, then the scan mode machine
// turns it combinationally into zero, one or two words and writes them into
// a four-word result queue, whose head is offered on the output. The rate is
// one character per cycle as long as each character yields at most one word
// and the output does not stall; characters that yield two words are limited
// by the queue's single read port to one word per cycle. After an error no
// words come out until the end-of-text word, which always ends in K_EOF.
// ----------------------------------------------------------------------------
module source_tokenizer
    import stok_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    stok_char_if.sink   char_in,
    stok_tok_if.source  tok_out
);

    item_t     item_reg;
    logic      item_vld_reg;
    logic      fire, room, not_empty;
    res_pair_t res;
    result_t   head;

    assign fire          = item_vld_reg && room;
    assign char_in.ready = !item_vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else if (char_in.ready)
        begin
            item_vld_reg <= char_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_in.valid && char_in.ready)
        begin
            item_reg <= '{ch: char_in.ch, end_of_text: char_in.end_of_text};
        end
    end

    stok_step u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .res   (res)
    );

    stok_rq u_rq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res),
        .pop       (tok_out.valid && tok_out.ready),
        .head      (head),
        .not_empty (not_empty),
        .room      (room)
    );

    assign tok_out.valid         = not_empty;
    assign tok_out.is_value_char = head.is_value_char;
    assign tok_out.value_char    = head.value_char;
    assign tok_out.token_kind    = head.token_kind;
    assign tok_out.keyword_index = head.keyword_index;
    assign tok_out.token_length  = head.token_length;
    assign tok_out.lex_error     = head.lex_error;

endmodule
